// ===== sv/dlr_pkg.sv =====
// shared types for the dda line rasterizer
`timescale 1ns / 1ps

package dlr_pkg;

    // status of the shared divider as seen by the sequencer
    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

// ===== sv/dlr_div.sv =====
// iterative restoring divider: (mag << FRAC_BITS) / divisor, one quotient bit a cycle
`timescale 1ns / 1ps

module dlr_div #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] dividend,
    input  logic [COORD_BITS-1:0] divisor,
    output logic [FRAC_BITS:0]    quotient,
    output dlr_pkg::div_stat_t    stat
);

    import dlr_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 2);

    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [COORD_BITS-1:0] dvs_reg, dvs_next;
    logic [FRAC_BITS:0]    quo_reg, quo_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic                  ge;
    logic [COORD_BITS:0]   diff;

    // dividend never exceeds divisor, so the quotient fits FRAC_BITS+1 bits
    // and the partial remainder stays below twice the divisor
    always_comb
    begin
        ge        = rem_reg >= {1'b0, dvs_reg};
        diff      = rem_reg - (ge ? {1'b0, dvs_reg} : '0);
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = {1'b0, dividend};
            dvs_next = divisor;
            quo_next = '0;
            cnt_next = CW'(FRAC_BITS + 1);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = {diff[COORD_BITS-1:0], 1'b0};
            quo_next  = {quo_reg[FRAC_BITS-1:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/dda_line_rasterizer.sv =====
// dda line rasterizer top level: sequencer, position datapath and output register
// output: every item's result sits in the output register in the cycle after acceptance
// throughput: a step item every cycle while the output is not stalled; a start item with a
// nonzero step count keeps the block busy while the shared one-bit-a-cycle divider runs x then y
// reset: asynchronous active low; idle, no line active, position and increments zero
`timescale 1ns / 1ps

module dda_line_rasterizer #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input item channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    // result item channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  valid_res,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last
);

    import dlr_pkg::*;

    // position: unsigned, COORD_BITS integer and FRAC_BITS fraction bits
    localparam int PW = COORD_BITS + FRAC_BITS;
    // increment: two's complement, one bit wider than a position
    localparam int SW = PW + 1;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_X,
        S_DIV_Y
    } state_t;

    state_t                state_reg, state_next;
    logic [PW-1:0]         pos_x_reg, pos_x_next;
    logic [PW-1:0]         pos_y_reg, pos_y_next;
    logic [SW-1:0]         step_x_reg, step_x_next;
    logic [SW-1:0]         step_y_reg, step_y_next;
    logic [COORD_BITS-1:0] steps_left_reg, steps_left_next;
    logic [COORD_BITS-1:0] ady_reg, ady_next;
    logic                  neg_x_reg, neg_x_next;
    logic                  neg_y_reg, neg_y_next;
    logic                  active_reg, active_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  valid_res_reg, valid_res_next;
    logic [COORD_BITS-1:0] pixel_x_reg, pixel_x_next;
    logic [COORD_BITS-1:0] pixel_y_reg, pixel_y_next;
    logic                  last_reg, last_next;

    logic                  accept;
    logic [COORD_BITS-1:0] adx, ady, steps;
    logic [PW-1:0]         adv_x, adv_y, rnd_x, rnd_y;
    logic [SW-1:0]         q_ext, q_signed;
    logic                  q_neg;

    // shared divider hookup
    logic                  div_start;
    logic [COORD_BITS-1:0] div_dividend, div_divisor;
    logic [FRAC_BITS:0]    div_quo;
    div_stat_t             div_stat;

    // accept a new item only when idle and the output register can take its result
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // endpoint deltas and the step count of a new line
    always_comb
    begin
        adx   = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
        ady   = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
        steps = (adx > ady) ? adx : ady;
    end

    // next position on a step item, wrapping, and its round-half-up pixel
    always_comb
    begin
        adv_x = pos_x_reg + step_x_reg[PW-1:0];
        adv_y = pos_y_reg + step_y_reg[PW-1:0];
        rnd_x = adv_x + HALF;
        rnd_y = adv_y + HALF;
    end

    // divider runs |dx| first, straight off the start item, then |dy|;
    // the divisor is steps, held in steps_left while dividing
    assign div_start    = (accept && !mode && (steps != '0))
                       || (state_reg == S_DIV_X && div_stat.done);
    assign div_dividend = (state_reg == S_DIV_X) ? ady_reg : adx;
    assign div_divisor  = (state_reg == S_IDLE) ? steps : steps_left_reg;

    // increment rounds toward zero: the magnitude quotient with the delta's sign
    always_comb
    begin
        q_neg    = (state_reg == S_DIV_X) ? neg_x_reg : neg_y_reg;
        q_ext    = {{COORD_BITS{1'b0}}, div_quo};
        q_signed = q_neg ? SW'(0) - q_ext : q_ext;
    end

    dlr_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        steps_left_next = steps_left_reg;
        ady_next        = ady_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        active_next     = active_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        valid_res_next  = valid_res_reg;
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        last_next       = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    if (!mode)
                    begin
                        // new line, abandoning any line in progress; start pixel goes out now
                        pos_x_next      = {start_x, {FRAC_BITS{1'b0}}};
                        pos_y_next      = {start_y, {FRAC_BITS{1'b0}}};
                        steps_left_next = steps;
                        ady_next        = ady;
                        neg_x_next      = end_x < start_x;
                        neg_y_next      = end_y < start_y;
                        step_x_next     = '0;
                        step_y_next     = '0;
                        active_next     = 1'b0;
                        valid_res_next  = 1'b1;
                        pixel_x_next    = start_x;
                        pixel_y_next    = start_y;
                        last_next       = (steps == '0);
                        if (steps != '0)
                        begin
                            state_next = S_DIV_X;
                        end
                    end
                    else if (active_reg)
                    begin
                        pos_x_next      = adv_x;
                        pos_y_next      = adv_y;
                        steps_left_next = steps_left_reg - 1'b1;
                        active_next     = (steps_left_reg != COORD_BITS'(1));
                        valid_res_next  = 1'b1;
                        pixel_x_next    = rnd_x[PW-1:FRAC_BITS];
                        pixel_y_next    = rnd_y[PW-1:FRAC_BITS];
                        last_next       = (steps_left_reg == COORD_BITS'(1));
                    end
                    else
                    begin
                        // step with no line: empty result
                        valid_res_next = 1'b0;
                        pixel_x_next   = '0;
                        pixel_y_next   = '0;
                        last_next      = 1'b0;
                    end
                end
            end
            S_DIV_X:
            begin
                if (div_stat.done)
                begin
                    step_x_next = q_signed;
                    state_next  = S_DIV_Y;
                end
            end
            S_DIV_Y:
            begin
                if (div_stat.done)
                begin
                    step_y_next = q_signed;
                    active_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            steps_left_reg <= '0;
            ady_reg        <= '0;
            neg_x_reg      <= 1'b0;
            neg_y_reg      <= 1'b0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            valid_res_reg  <= 1'b0;
            pixel_x_reg    <= '0;
            pixel_y_reg    <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            steps_left_reg <= steps_left_next;
            ady_reg        <= ady_next;
            neg_x_reg      <= neg_x_next;
            neg_y_reg      <= neg_y_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
            valid_res_reg  <= valid_res_next;
            pixel_x_reg    <= pixel_x_next;
            pixel_y_reg    <= pixel_y_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign last      = last_reg;

endmodule
